[hdl/pwu_pkg.sv]
`default_nettype none

package pwu_pkg;

   // default sizes of the weight store
   localparam int NUM_FEATURES_DEF = 1024;
   localparam int WEIGHT_BITS_DEF  = 32;

   // fixed field widths
   localparam int WORD_W    = 32;
   localparam int FEAT_W    = 10;
   localparam int FRAC_W    = 16;
   localparam int CSR_IDX_W = 2;

   // shared multiplier: magnitude of a 33-bit difference times a 32-bit coefficient
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // step after the fraction shift, with sign, and the sum with a weight
   localparam int DELTA_W = MUL_P_W - FRAC_W + 1;
   localparam int SUM_W   = DELTA_W + 1;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_L1_COEFF      = 2'd1,
      CSR_WEIGHT_MIN    = 2'd2,
      CSR_WEIGHT_MAX    = 2'd3
   } csr_index_type;

   // configuration reset values
   localparam logic [WORD_W-1:0] LR_RESET   = 32'h0001_0000;
   localparam logic [WORD_W-1:0] L1_RESET   = 32'h0000_0000;
   localparam logic [WORD_W-1:0] WMIN_RESET = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WMAX_RESET = 32'h7FFF_FFFF;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_DECAY,
      ST_STEP,
      ST_SUM,
      ST_DONE
   } state_type;

   // request to the shared multiplier
   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

[hdl/perceptron_weight_update_l1_unit.sv]
`default_nettype none

// Perceptron weight store with lazy L1 decay toward zero.
// Command channel: a beat is taken at a clock edge with start high and busy low;
// req_action selects an update (0) or a read of the decayed weight (1).
// Result channel: one beat per command, rsp_valid high for exactly one cycle
// with rsp_weight_value and rsp_update_applied; the receiver cannot stall it.
// Configuration: csr_valid/csr_ready with csr_index and csr_wdata, always ready;
// write it only while busy is low and no result is outstanding.
// Sequence: a command that touches the store runs read, load, decay, step, sum and
// done on one shared 33x32 multiplier with busy high, and the result follows in the
// cycle after the done step; the next command can be taken once busy is low again.
// An update without a feature skips the store and goes straight to the done step.
// Reset: after reset the store is cleared one entry per cycle, all NUM_FEATURES
// entries with busy high; configuration writes are taken during the sweep.
// The iteration counter advances on an update command with end_of_update set.
module perceptron_weight_update_l1_unit #(
   parameter int NUM_FEATURES = pwu_pkg::NUM_FEATURES_DEF,
   parameter int WEIGHT_BITS  = pwu_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // command beat
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic                                    req_action,
   input  wire logic        [pwu_pkg::FEAT_W-1:0]       req_feature_index,
   input  wire logic                                    req_has_feature,
   input  wire logic signed [pwu_pkg::WORD_W-1:0]       req_oracle_value,
   input  wire logic signed [pwu_pkg::WORD_W-1:0]       req_system_value,
   input  wire logic signed [pwu_pkg::WORD_W-1:0]       req_gold_score,
   input  wire logic signed [pwu_pkg::WORD_W-1:0]       req_hyp_score,
   input  wire logic                                    req_end_of_update,
   // result beat
   output logic                                         rsp_valid,
   output logic signed      [pwu_pkg::WORD_W-1:0]       rsp_weight_value,
   output logic                                         rsp_update_applied,
   // configuration
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic        [pwu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic        [pwu_pkg::WORD_W-1:0]       csr_wdata
);

   localparam int WORD_W  = pwu_pkg::WORD_W;
   localparam int FEAT_W  = pwu_pkg::FEAT_W;
   localparam int FRAC_W  = pwu_pkg::FRAC_W;
   localparam int MUL_A_W = pwu_pkg::MUL_A_W;
   localparam int MUL_P_W = pwu_pkg::MUL_P_W;
   localparam int DELTA_W = pwu_pkg::DELTA_W;
   localparam int SUM_W   = pwu_pkg::SUM_W;

   localparam int IDX_W = $clog2(NUM_FEATURES);
   localparam int RED_W = IDX_W + FEAT_W;
   localparam int WT_W  = (WEIGHT_BITS > WORD_W) ? WORD_W : WEIGHT_BITS;

   localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NUM_FEATURES - 1);

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (WT_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(64'sd1 <<< (WT_W - 1)));

   // index modulo the table depth, by restoring subtraction of shifted depths
   function automatic logic [IDX_W-1:0] wrap_index(input logic [FEAT_W-1:0] raw);
      logic [RED_W-1:0] v;
      v = RED_W'(raw);
      for (int k = FEAT_W - 1; k >= 0; k--) begin
         if (v >= (RED_W'(NUM_FEATURES) << k)) begin
            v = v - (RED_W'(NUM_FEATURES) << k);
         end
      end
      return v[IDX_W-1:0];
   endfunction

   // configured range, then the signed range of the stored weight
   function automatic logic [WORD_W-1:0] clamp_word(
      input logic signed [SUM_W-1:0]  v,
      input logic signed [WORD_W-1:0] lo,
      input logic signed [WORD_W-1:0] hi
   );
      logic signed [SUM_W-1:0] r;
      logic signed [SUM_W-1:0] lo_x;
      logic signed [SUM_W-1:0] hi_x;
      lo_x = SUM_W'(lo);
      hi_x = SUM_W'(hi);
      r    = v;
      if (r < lo_x) begin
         r = lo_x;
      end
      if (r > hi_x) begin
         r = hi_x;
      end
      if (r > SAT_MAX) begin
         r = SAT_MAX;
      end
      if (r < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[WORD_W-1:0];
   endfunction

   // control state
   pwu_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [WORD_W-1:0]  iter_ff, iter_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [WORD_W-1:0]  lr_ff, lr_in;
   logic [WORD_W-1:0]  l1_ff, l1_in;
   logic [WORD_W-1:0]  wmin_ff, wmin_in;
   logic [WORD_W-1:0]  wmax_ff, wmax_in;

   // command and working registers
   logic               act_ff, act_in;
   logic               has_feat_ff, has_feat_in;
   logic               eou_ff, eou_in;
   logic               applied_ff, applied_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MUL_A_W-1:0] d_ff, d_in;
   logic [WORD_W-1:0]  w_ff, w_in;
   logic               ev_nz_ff, ev_nz_in;
   logic [WORD_W-1:0]  dec_ff, dec_in;
   logic               touch_ff, touch_in;
   logic [WORD_W-1:0]  dw_ff, dw_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [WORD_W-1:0]  rsp_weight_ff, rsp_weight_in;
   logic               rsp_applied_ff, rsp_applied_in;

   // store ports
   logic               wt_wr_en, wt_rd_en;
   logic [IDX_W-1:0]   wt_wr_addr;
   logic [WT_W-1:0]    wt_wr_data, wt_rd_data;
   logic [WORD_W-1:0]  mk_wr_data, mk_rd_data;

   // shared multiplier
   pwu_pkg::mul_req_type mul_req;
   logic [MUL_P_W-1:0]   mul_prod;

   // combinational helpers
   logic                       accept;
   logic [WORD_W-1:0]          elapsed;
   logic                       w_neg;
   logic [WORD_W-1:0]          w_abs;
   logic                       decay_ge;
   logic [MUL_P_W-1:0]         mag_rnd;
   logic [MUL_P_W-FRAC_W-1:0]  step_q;
   logic [WORD_W-1:0]          new_w;

   pwu_ram #(
      .WIDTH (WT_W),
      .DEPTH (NUM_FEATURES)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_en   (wt_rd_en),
      .rd_addr (idx_ff),
      .rd_data (wt_rd_data)
   );

   pwu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_FEATURES)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (mk_wr_data),
      .rd_en   (wt_rd_en),
      .rd_addr (idx_ff),
      .rd_data (mk_rd_data)
   );

   pwu_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (mul_prod)
   );

   assign busy      = (state_ff != pwu_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // decay terms from the loaded entry and the elapsed-times-coefficient product
   assign elapsed  = iter_ff - mk_rd_data;
   assign w_neg    = w_ff[WORD_W-1];
   assign w_abs    = w_neg ? (WORD_W'(0) - w_ff) : w_ff;
   assign decay_ge = (|mul_prod[MUL_P_W-1:WORD_W]) || (mul_prod[WORD_W-1:0] >= w_abs);

   // step rounded toward minus infinity: ceiling of the magnitude when negative
   assign mag_rnd = d_ff[MUL_A_W-1] ? (mul_prod + MUL_P_W'(16'hFFFF)) : mul_prod;
   assign step_q  = mag_rnd[MUL_P_W-1:FRAC_W];

   // final clamp of decayed weight plus step
   assign new_w = clamp_word(sum_ff, wmin_ff, wmax_ff);

   // configuration writes
   always_comb begin
      lr_in   = lr_ff;
      l1_in   = l1_ff;
      wmin_in = wmin_ff;
      wmax_in = wmax_ff;
      if (csr_valid) begin
         case (csr_index)
            pwu_pkg::CSR_LEARNING_RATE: lr_in   = csr_wdata;
            pwu_pkg::CSR_L1_COEFF:      l1_in   = csr_wdata;
            pwu_pkg::CSR_WEIGHT_MIN:    wmin_in = csr_wdata;
            pwu_pkg::CSR_WEIGHT_MAX:    wmax_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer: next state, datapath steps, store and multiplier control
   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      iter_in        = iter_ff;
      rsp_valid_in   = 1'b0;
      act_in         = act_ff;
      has_feat_in    = has_feat_ff;
      eou_in         = eou_ff;
      applied_in     = applied_ff;
      idx_in         = idx_ff;
      d_in           = d_ff;
      w_in           = w_ff;
      ev_nz_in       = ev_nz_ff;
      dec_in         = dec_ff;
      touch_in       = touch_ff;
      dw_in          = dw_ff;
      delta_in       = delta_ff;
      sum_in         = sum_ff;
      rsp_weight_in  = rsp_weight_ff;
      rsp_applied_in = rsp_applied_ff;
      wt_wr_en       = 1'b0;
      wt_rd_en       = 1'b0;
      wt_wr_addr     = idx_ff;
      wt_wr_data     = '0;
      mk_wr_data     = iter_ff;
      mul_req        = '0;

      case (state_ff)
         // clearing sweep after reset
         pwu_pkg::ST_CLEAR: begin
            wt_wr_en   = 1'b1;
            wt_wr_addr = clr_addr_ff;
            mk_wr_data = '0;
            clr_addr_in = clr_addr_ff + IDX_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = pwu_pkg::ST_IDLE;
            end
         end

         // take a command beat
         pwu_pkg::ST_IDLE: begin
            if (accept) begin
               act_in      = req_action;
               has_feat_in = req_has_feature;
               eou_in      = req_end_of_update;
               applied_in  = req_hyp_score >= req_gold_score;
               idx_in      = wrap_index(req_feature_index);
               d_in        = $signed({req_oracle_value[WORD_W-1], req_oracle_value})
                           - $signed({req_system_value[WORD_W-1], req_system_value});
               if (!req_action && !req_has_feature) begin
                  state_in = pwu_pkg::ST_DONE;
               end else begin
                  state_in = pwu_pkg::ST_READ;
               end
            end
         end

         // read weight and mark
         pwu_pkg::ST_READ: begin
            wt_rd_en = 1'b1;
            state_in = pwu_pkg::ST_LOAD;
         end

         // load entry, multiply elapsed iterations by the coefficient
         pwu_pkg::ST_LOAD: begin
            w_in      = WORD_W'($signed(wt_rd_data));
            ev_nz_in  = (elapsed != '0);
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(elapsed);
            mul_req.b  = l1_ff;
            state_in  = pwu_pkg::ST_DECAY;
         end

         // move toward zero without crossing it; multiply step magnitude
         pwu_pkg::ST_DECAY: begin
            touch_in = (w_ff != '0) && ev_nz_ff;
            if ((w_ff == '0) || !ev_nz_ff) begin
               dec_in = w_ff;
            end else if (decay_ge) begin
               dec_in = '0;
            end else if (w_neg) begin
               dec_in = w_ff + mul_prod[WORD_W-1:0];
            end else begin
               dec_in = w_ff - mul_prod[WORD_W-1:0];
            end
            mul_req.en = 1'b1;
            mul_req.a  = d_ff[MUL_A_W-1] ? (MUL_A_W'(0) - d_ff) : d_ff;
            mul_req.b  = lr_ff;
            state_in   = pwu_pkg::ST_STEP;
         end

         // clamp a decayed nonzero weight; scale the step
         pwu_pkg::ST_STEP: begin
            if (touch_ff && (dec_ff != '0)) begin
               dw_in = clamp_word(SUM_W'($signed(dec_ff)), wmin_ff, wmax_ff);
            end else begin
               dw_in = dec_ff;
            end
            if (d_ff[MUL_A_W-1]) begin
               delta_in = DELTA_W'(0) - {1'b0, step_q};
            end else begin
               delta_in = {1'b0, step_q};
            end
            state_in = pwu_pkg::ST_SUM;
         end

         // add the step to the decayed weight
         pwu_pkg::ST_SUM: begin
            sum_in   = SUM_W'($signed(dw_ff)) + SUM_W'($signed(delta_ff));
            state_in = pwu_pkg::ST_DONE;
         end

         // write back, form the result beat, advance iteration
         pwu_pkg::ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_applied_in = !act_ff && applied_ff;
            if (act_ff) begin
               rsp_weight_in = dw_ff;
               wt_wr_en      = touch_ff;
               wt_wr_data    = WT_W'(dw_ff);
            end else if (!has_feat_ff) begin
               rsp_weight_in = '0;
            end else if (applied_ff) begin
               rsp_weight_in = new_w;
               wt_wr_en      = 1'b1;
               wt_wr_data    = WT_W'(new_w);
            end else begin
               rsp_weight_in = w_ff;
            end
            if (!act_ff && eou_ff) begin
               iter_in = iter_ff + WORD_W'(1);
            end
            state_in = pwu_pkg::ST_IDLE;
         end

         default: begin
            state_in = pwu_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwu_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= pwu_pkg::LR_RESET;
         l1_ff        <= pwu_pkg::L1_RESET;
         wmin_ff      <= pwu_pkg::WMIN_RESET;
         wmax_ff      <= pwu_pkg::WMAX_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         l1_ff        <= l1_in;
         wmin_ff      <= wmin_in;
         wmax_ff      <= wmax_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      has_feat_ff    <= has_feat_in;
      eou_ff         <= eou_in;
      applied_ff     <= applied_in;
      idx_ff         <= idx_in;
      d_ff           <= d_in;
      w_ff           <= w_in;
      ev_nz_ff       <= ev_nz_in;
      dec_ff         <= dec_in;
      touch_ff       <= touch_in;
      dw_ff          <= dw_in;
      delta_ff       <= delta_in;
      sum_ff         <= sum_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_applied_ff <= rsp_applied_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_weight_value   = rsp_weight_ff;
   assign rsp_update_applied = rsp_applied_ff;

   // a result beat only follows the done step
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == pwu_pkg::ST_DONE))
      else $error("result beat without a finished command");

   // iteration counter moves only on the done step
   a_iter_only_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff != pwu_pkg::ST_DONE) |=> $stable(iter_ff))
      else $error("iteration counter changed outside the done step");

   // an accepted command makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after a command beat");

endmodule

`default_nettype wire

[hdl/pwu_ram.sv]
`default_nettype none

module pwu_ram #(
   parameter int WIDTH = pwu_pkg::WORD_W,
   parameter int DEPTH = pwu_pkg::NUM_FEATURES_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/pwu_mul.sv]
`default_nettype none

module pwu_mul (
   input  wire logic                           clock,
   input  wire pwu_pkg::mul_req_type           req,
   output logic      [pwu_pkg::MUL_P_W-1:0]    prod
);

   logic [pwu_pkg::MUL_P_W-1:0] prod_in;
   logic [pwu_pkg::MUL_P_W-1:0] prod_ff;

   // unsigned product, registered
   assign prod_in = req.a * req.b;

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

[tb/tb_perceptron_weight_update_l1_unit.sv]
`default_nettype none

module tb_perceptron_weight_update_l1_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORD_W    = pwu_pkg::WORD_W;
   localparam int FEAT_W    = pwu_pkg::FEAT_W;
   localparam int FRAC_W    = pwu_pkg::FRAC_W;
   localparam int CSR_IDX_W = pwu_pkg::CSR_IDX_W;

   // command kinds carried on req_action
   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   localparam int                 NUM_ENTRIES = pwu_pkg::NUM_FEATURES_DEF;
   localparam int                 LAST_INDEX  = pwu_pkg::NUM_FEATURES_DEF - 1;
   localparam int                 ONE         = 1 << FRAC_W;
   localparam logic signed [31:0] W_MAX       = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] W_MIN       = 32'sh8000_0000;
   localparam int                 STALL_LIMIT = 4000;
   localparam int                 GAP_MAX     = 11;

   typedef struct {
      logic                     action;
      logic [FEAT_W-1:0]        index;
      logic                     has_feature;
      logic signed [WORD_W-1:0] oracle_value;
      logic signed [WORD_W-1:0] system_value;
      logic signed [WORD_W-1:0] gold_score;
      logic signed [WORD_W-1:0] hyp_score;
      logic                     end_of_update;
   } weight_cmd_type;

   typedef struct {
      logic signed [WORD_W-1:0] weight;
      logic                     applied;
   } weight_rsp_type;

   // mirror of the weight store, touch marks and settings; queues the expected weights
   class weight_tracker;
      logic signed [WORD_W-1:0] weights [NUM_ENTRIES];
      logic [WORD_W-1:0]        marks [NUM_ENTRIES];
      logic [WORD_W-1:0]        iteration;
      logic [WORD_W-1:0]        rate;
      logic [WORD_W-1:0]        l1_rate;
      logic signed [WORD_W-1:0] wmin;
      logic signed [WORD_W-1:0] wmax;
      weight_rsp_type           pending_weights[$];
      int                       mismatches;
      int                       checked;

      function new();
         foreach (weights[i]) begin
            weights[i] = '0;
            marks[i]   = '0;
         end
         iteration  = '0;
         rate       = pwu_pkg::LR_RESET;
         l1_rate    = pwu_pkg::L1_RESET;
         wmin       = pwu_pkg::WMIN_RESET;
         wmax       = pwu_pkg::WMAX_RESET;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_register(pwu_pkg::csr_index_type idx, logic [WORD_W-1:0] value);
         case (idx)
            pwu_pkg::CSR_LEARNING_RATE: rate    = value;
            pwu_pkg::CSR_L1_COEFF:      l1_rate = value;
            pwu_pkg::CSR_WEIGHT_MIN:    wmin    = value;
            pwu_pkg::CSR_WEIGHT_MAX:    wmax    = value;
            default: ;
         endcase
      endfunction

      // upper bound wins when the range is inverted
      function logic signed [WORD_W-1:0] clamp_to_range(longint v);
         if (v < longint'(wmin)) v = wmin;
         if (v > longint'(wmax)) v = wmax;
         return v[31:0];
      endfunction

      // lazy shrink toward zero for the iterations since the last touch
      function longint decay_entry(int idx);
         longint            w;
         logic [WORD_W-1:0] elapsed;
         bit [63:0]         amount;
         bit [63:0]         size_w;
         w       = weights[idx];
         elapsed = iteration - marks[idx];
         if (w == 0 || elapsed == 0) return w;
         amount = {32'b0, elapsed} * {32'b0, l1_rate};
         if (w > 0) begin
            size_w = w;
            if (amount >= size_w) w = 0;
            else w = w - longint'(amount);
         end else begin
            size_w = -w;
            if (amount >= size_w) w = 0;
            else w = w + longint'(amount);
         end
         if (w != 0) w = clamp_to_range(w);
         weights[idx] = w[31:0];
         marks[idx]   = iteration;
         return w;
      endfunction

      function void note_command(weight_cmd_type c);
         weight_rsp_type r;
         longint         w;
         longint         d;
         longint         delta;
         bit [63:0]      size_d;
         bit [63:0]      mag;
         int             idx;
         idx       = int'(c.index);
         r.weight  = '0;
         r.applied = 1'b0;
         if (c.action == ACT_READ) begin
            w        = decay_entry(idx);
            r.weight = w[31:0];
         end else begin
            r.applied = (c.hyp_score >= c.gold_score);
            if (c.has_feature) begin
               if (r.applied) begin
                  w      = decay_entry(idx);
                  d      = longint'(c.oracle_value) - longint'(c.system_value);
                  size_d = (d < 0) ? -d : d;
                  mag    = size_d * {32'b0, rate};
                  // fraction shift rounds toward minus infinity
                  if (d < 0) delta = -longint'((mag + 64'hFFFF) >> FRAC_W);
                  else delta = longint'(mag >> FRAC_W);
                  weights[idx] = clamp_to_range(w + delta);
                  marks[idx]   = iteration;
               end
               r.weight = weights[idx];
            end
            if (c.end_of_update) iteration = iteration + 1;
         end
         pending_weights.push_back(r);
      endfunction

      function void check_result(logic signed [WORD_W-1:0] weight, logic applied);
         weight_rsp_type e;
         if (pending_weights.size() == 0) begin
            $display("%0t: unexpected result beat, weight %0d applied %0b",
                     $time, weight, applied);
            mismatches++;
            return;
         end
         e = pending_weights.pop_front();
         checked++;
         if (weight !== e.weight) begin
            $display("%0t: weight_value expected %0d actual %0d", $time, e.weight, weight);
            mismatches++;
         end
         if (applied !== e.applied) begin
            $display("%0t: update_applied expected %0b actual %0b",
                     $time, e.applied, applied);
            mismatches++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_action;
   logic [FEAT_W-1:0]        req_feature_index;
   logic                     req_has_feature;
   logic signed [WORD_W-1:0] req_oracle_value;
   logic signed [WORD_W-1:0] req_system_value;
   logic signed [WORD_W-1:0] req_gold_score;
   logic signed [WORD_W-1:0] req_hyp_score;
   logic                     req_end_of_update;
   logic                     rsp_valid;
   logic signed [WORD_W-1:0] rsp_weight_value;
   logic                     rsp_update_applied;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [WORD_W-1:0]        csr_wdata;

   weight_tracker tracker;
   int            quiet_cycles;
   int            commands_sent;
   int            csr_writes;
   int            settings_used;

   perceptron_weight_update_l1_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_feature_index  (req_feature_index),
      .req_has_feature    (req_has_feature),
      .req_oracle_value   (req_oracle_value),
      .req_system_value   (req_system_value),
      .req_gold_score     (req_gold_score),
      .req_hyp_score      (req_hyp_score),
      .req_end_of_update  (req_end_of_update),
      .rsp_valid          (rsp_valid),
      .rsp_weight_value   (rsp_weight_value),
      .rsp_update_applied (rsp_update_applied),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result beats checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_result(rsp_weight_value, rsp_update_applied);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic weight_cmd_type make_cmd(logic act, int idx, logic hf,
                                               logic signed [31:0] ov, logic signed [31:0] sv,
                                               logic signed [31:0] os, logic signed [31:0] ss,
                                               logic eou);
      weight_cmd_type c;
      c.action        = act;
      c.index         = idx[FEAT_W-1:0];
      c.has_feature   = hf;
      c.oracle_value  = ov;
      c.system_value  = sv;
      c.gold_score    = os;
      c.hyp_score     = ss;
      c.end_of_update = eou;
      return c;
   endfunction

   // mostly small Q16.16 numbers, some extremes and some raw words
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return int'($urandom_range(0, 16 * ONE)) - 8 * ONE;
      if (r < 80) begin
         case ($urandom_range(0, 3))
            0: return W_MAX;
            1: return W_MIN;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // a handful of hot entries so that weights build up and decay
   function automatic int pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 7);
      if (r < 85) return $urandom_range(LAST_INDEX - 7, LAST_INDEX);
      return $urandom_range(0, LAST_INDEX);
   endfunction

   function automatic int pick_gap(int gap_max);
      if (gap_max == 0 || $urandom_range(0, 99) < 30) return 0;
      return $urandom_range(0, gap_max);
   endfunction

   // one command beat, entered and left at a falling edge
   task automatic send_command(weight_cmd_type c, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_action        <= c.action;
      req_feature_index <= c.index;
      req_has_feature   <= c.has_feature;
      req_oracle_value  <= c.oracle_value;
      req_system_value  <= c.system_value;
      req_gold_score    <= c.gold_score;
      req_hyp_score     <= c.hyp_score;
      req_end_of_update <= c.end_of_update;
      do @(posedge clock); while (busy);
      tracker.note_command(c);
      commands_sent++;
      @(negedge clock);
   endtask

   // valid is left high for the next write; the caller drops it
   task automatic write_csr(pwu_pkg::csr_index_type idx, logic [WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, value);
      csr_writes++;
      @(negedge clock);
   endtask

   // sender holds off until every expected beat is back and the unit is idle
   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (tracker.pending_weights.size() != 0 || busy) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic apply_settings(logic [31:0] lr, logic [31:0] l1c,
                                 logic [31:0] mn, logic [31:0] mx);
      drain_results();
      write_csr(pwu_pkg::CSR_LEARNING_RATE, lr);
      write_csr(pwu_pkg::CSR_L1_COEFF, l1c);
      write_csr(pwu_pkg::CSR_WEIGHT_MIN, mn);
      write_csr(pwu_pkg::CSR_WEIGHT_MAX, mx);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // reads, stray updates and whole updates ending on the end flag
   task automatic run_phase(logic [31:0] lr, logic [31:0] l1c, logic [31:0] mn,
                            logic [31:0] mx, int count, int gap_max);
      int                 sent;
      int                 r;
      int                 len;
      weight_cmd_type     c;
      logic signed [31:0] os;
      logic signed [31:0] ss;
      apply_settings(lr, l1c, mn, mx);
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            c = make_cmd(ACT_READ, pick_index(), 1'($urandom_range(0, 1)), pick_value(),
                         pick_value(), pick_value(), pick_value(),
                         1'($urandom_range(0, 1)));
            send_command(c, pick_gap(gap_max));
            sent++;
         end else if (r < 22) begin
            c = make_cmd(ACT_UPDATE, pick_index(), 1'($urandom_range(0, 1)), pick_value(),
                         pick_value(), pick_value(), pick_value(),
                         1'($urandom_range(0, 1)));
            send_command(c, pick_gap(gap_max));
            sent++;
         end else begin
            len = $urandom_range(1, 4);
            os  = pick_value();
            r   = $urandom_range(0, 99);
            if (r < 20) ss = os;
            else if (r < 70) ss = os + int'($urandom_range(1, 2 * ONE));
            else ss = pick_value();
            for (int i = 0; i < len; i++) begin
               c = make_cmd(ACT_UPDATE, pick_index(), $urandom_range(0, 9) != 0,
                            pick_value(), pick_value(), os, ss, i == len - 1);
               send_command(c, pick_gap(gap_max));
               sent++;
            end
         end
      end
   endtask

   // stimulus
   initial begin
      tracker           = new();
      quiet_cycles      = 0;
      commands_sent     = 0;
      csr_writes        = 0;
      settings_used     = 0;
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_UPDATE;
      req_feature_index = '0;
      req_has_feature   = 1'b0;
      req_oracle_value  = '0;
      req_system_value  = '0;
      req_gold_score    = '0;
      req_hyp_score     = '0;
      req_end_of_update = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = pwu_pkg::CSR_LEARNING_RATE;
      csr_wdata         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: untouched read, score boundary, failed test, decay to zero, clamps
      apply_settings(ONE, ONE / 4, W_MIN, W_MAX);
      send_command(make_cmd(ACT_READ, 0, 1'b1, 0, 0, 0, 0, 1'b0), 0);
      send_command(make_cmd(ACT_UPDATE, 0, 1'b1, 3 * ONE, ONE, 0, 0, 1'b1), 0);
      send_command(make_cmd(ACT_UPDATE, 0, 1'b1, 5 * ONE, 0, ONE, 0, 1'b0), 1);
      send_command(make_cmd(ACT_READ, 0, 1'b0, 0, 0, 0, 0, 1'b1), 0);
      for (int i = 0; i < 4; i++) begin
         send_command(make_cmd(ACT_UPDATE, 0, 1'b0, 0, 0, -ONE, ONE, 1'b1),
                      $urandom_range(0, 3));
      end
      send_command(make_cmd(ACT_READ, 0, 1'b1, 0, 0, 0, 0, 1'b0), 0);
      send_command(make_cmd(ACT_UPDATE, 9, 1'b0, ONE, 0, W_MAX, W_MIN, 1'b0), 2);
      send_command(make_cmd(ACT_UPDATE, LAST_INDEX, 1'b1, 0, 1, 0, 0, 1'b0), 0);
      send_command(make_cmd(ACT_UPDATE, LAST_INDEX, 1'b1, W_MAX, W_MIN, W_MIN, W_MAX, 1'b0),
                   0);
      send_command(make_cmd(ACT_UPDATE, 512, 1'b1, W_MIN, W_MAX, W_MAX, W_MAX, 1'b1), 3);
      for (int i = 0; i < 3; i++) begin
         send_command(make_cmd(ACT_UPDATE, 0, 1'b0, 0, 0, 0, 0, 1'b1), 0);
      end
      send_command(make_cmd(ACT_READ, 0, 1'b1, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0), 0);
      send_command(make_cmd(ACT_READ, 512, 1'b0, 0, 0, 0, 0, 1'b0), 5);
      send_command(make_cmd(ACT_READ, LAST_INDEX, 1'b0, 0, 0, 0, 0, 1'b0), 0);
      send_command(make_cmd(ACT_UPDATE, 0, 1'b1, ONE, ONE, 0, 0, 1'b0), 0);
      send_command(make_cmd(ACT_UPDATE, 7, 1'b1, -ONE / 2, 0, -1, -1, 1'b1), 11);

      // random phases over several register settings, extremes included
      run_phase(ONE, ONE / 4, -16 * ONE, 16 * ONE, 125, GAP_MAX);
      run_phase(32'hFFFF_FFFF, 0, W_MIN, W_MAX, 125, GAP_MAX);
      run_phase(0, 32'hFFFF_FFFF, W_MIN, W_MAX, 125, 0);
      run_phase(ONE / 2, 32'h100, 3 * ONE, 3 * ONE, 125, GAP_MAX);
      run_phase(ONE + ONE / 2, ONE / 8, 5 * ONE, -5 * ONE, 125, 3);
      for (int p = 0; p < 3; p++) begin
         run_phase($urandom_range(0, 4 * ONE) | $urandom_range(0, 1),
                   $urandom_range(0, ONE / 2),
                   -int'($urandom_range(0, 32'h7FFF_FFFF)),
                   $urandom_range(0, 32'h7FFF_FFFF), 125, GAP_MAX);
      end

      // wind down
      drain_results();
      repeat (10) @(negedge clock);
      if (tracker.pending_weights.size() != 0) begin
         $display("%0t: %0d expected results never arrived",
                  $time, tracker.pending_weights.size());
         tracker.mismatches++;
      end
      $display("ran %0d commands under %0d register settings (%0d register writes)",
               commands_sent, settings_used, csr_writes);
      $display("checked %0d result beats, iteration counter reached %0d",
               tracker.checked, tracker.iteration);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
hdl/pwu_pkg.sv
hdl/pwu_ram.sv
hdl/pwu_mul.sv
hdl/perceptron_weight_update_l1_unit.sv
tb/tb_perceptron_weight_update_l1_unit.sv
